@@ src/cdeq_pkg.sv @@
// Package for the circular double-ended queue: sizes, command and status codes,
// beat structs and circular index helpers. No dependencies.
`default_nettype none

package cdeq_pkg;

  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int PORT_W     = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISPLAY    = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [DATA_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [PORT_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [PORT_W-1:0] data_out;
    logic                     last;
    logic                     is_full;
    logic                     is_empty;
  } rsp_t;

  function automatic idx_t step_up(input idx_t i);
    idx_t r;
    if (i == idx_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

  function automatic idx_t step_down(input idx_t i);
    idx_t r;
    if (i == '0) begin
      r = idx_t'(DEPTH - 1);
    end else begin
      r = i - idx_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/circular_double_ended_queue_core.sv @@
// Top level of the circular double-ended queue: pointer control, element store and result register.
// Depends on cdeq_pkg.
`default_nettype none

// Commands are taken one at a time; req_ready is high only while the block is idle. A push, or
// any command that overflows, underflows or displays an empty queue, passes through S_EXEC and
// gives its result beat in S_OUT. A successful pop passes through S_EXEC, S_READ and S_OUT, as the
// element comes through the registered read port of the store. Display gives one beat per stored
// element, each passing through S_WALK, S_READ and S_OUT, the next starting only after the previous
// beat is taken, since every element passes through that single read port. The block is ready
// again in the cycle after the last beat is taken; unused command codes give no beat and return
// the block from S_EXEC to idle. The store needs no clearing after reset.
module circular_double_ended_queue_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_ready,
  input  wire cdeq_pkg::req_t req,
  output      logic          rsp_valid,
  input  wire logic          rsp_ready,
  output      cdeq_pkg::rsp_t rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state, state_next;
  logic [cdeq_pkg::CMD_W-1:0] cmd;
  cdeq_pkg::elem_t value;
  cdeq_pkg::idx_t head, head_next;
  cdeq_pkg::idx_t tail, tail_next;
  logic empty, empty_next;
  cdeq_pkg::idx_t walk, walk_next;
  cdeq_pkg::idx_t count, count_next;

  logic [cdeq_pkg::STATUS_W-1:0] res_status, res_status_next;
  cdeq_pkg::elem_t res_data, res_data_next;
  logic res_last, res_last_next;

  cdeq_pkg::elem_t store [cdeq_pkg::DEPTH];
  cdeq_pkg::elem_t rd_q;
  cdeq_pkg::idx_t rd_addr;
  cdeq_pkg::idx_t wr_addr;
  logic wr_en;

  logic full;
  logic req_fire;
  logic rsp_fire;

  assign full      = !empty && (head == cdeq_pkg::step_up(tail));
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign req_fire  = req_valid && req_ready;
  assign rsp_fire  = rsp_valid && rsp_ready;

  assign rsp.status   = res_status;
  assign rsp.data_out = cdeq_pkg::PORT_W'(res_data);
  assign rsp.last     = res_last;
  assign rsp.is_full  = full;
  assign rsp.is_empty = empty;

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    empty_next      = empty;
    walk_next       = walk;
    count_next      = count;
    res_status_next = res_status;
    res_data_next   = res_data;
    res_last_next   = res_last;
    rd_addr         = head;
    wr_addr         = head;
    wr_en           = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_next = cdeq_pkg::STATUS_OK;
        res_data_next   = '0;
        res_last_next   = 1'b1;
        case (cmd)
          cdeq_pkg::CMD_PUSH_FRONT, cdeq_pkg::CMD_PUSH_REAR: begin
            state_next = S_OUT;
            if (full) begin
              res_status_next = cdeq_pkg::STATUS_OVERFLOW;
            end else begin
              wr_en = 1'b1;
              if (empty) begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b0;
                wr_addr    = '0;
              end else if (cmd == cdeq_pkg::CMD_PUSH_FRONT) begin
                head_next = cdeq_pkg::step_down(head);
                wr_addr   = cdeq_pkg::step_down(head);
              end else begin
                tail_next = cdeq_pkg::step_up(tail);
                wr_addr   = cdeq_pkg::step_up(tail);
              end
            end
          end
          cdeq_pkg::CMD_POP_FRONT, cdeq_pkg::CMD_POP_REAR: begin
            if (empty) begin
              res_status_next = cdeq_pkg::STATUS_UNDERFLOW;
              state_next      = S_OUT;
            end else begin
              state_next = S_READ;
              rd_addr    = (cmd == cdeq_pkg::CMD_POP_FRONT) ? head : tail;
              if (head == tail) begin
                empty_next = 1'b1;
                head_next  = '0;
                tail_next  = '0;
              end else if (cmd == cdeq_pkg::CMD_POP_FRONT) begin
                head_next = cdeq_pkg::step_up(head);
              end else begin
                tail_next = cdeq_pkg::step_down(tail);
              end
            end
          end
          cdeq_pkg::CMD_DISPLAY: begin
            if (empty) begin
              res_status_next = cdeq_pkg::STATUS_EMPTY;
              state_next      = S_OUT;
            end else begin
              walk_next  = head;
              count_next = '0;
              state_next = S_WALK;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        rd_addr         = walk;
        res_status_next = cdeq_pkg::STATUS_OK;
        res_last_next   = (walk == tail) || (count == cdeq_pkg::idx_t'(cdeq_pkg::DEPTH - 1));
        state_next      = S_READ;
      end
      S_READ: begin
        res_data_next = rd_q;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (rsp_fire) begin
          if (res_last) begin
            state_next = S_IDLE;
          end else begin
            walk_next  = cdeq_pkg::step_up(walk);
            count_next = count + cdeq_pkg::idx_t'(1);
            state_next = S_WALK;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd   <= req.cmd;
      value <= cdeq_pkg::DATA_WIDTH'($unsigned(req.data_in));
    end
    walk       <= walk_next;
    count      <= count_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    res_last   <= res_last_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= value;
    end
    rd_q <= store[rd_addr];
  end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for circular_double_ended_queue_core: a directed table followed by
// random command streams, each beat checked against the table or a behavioural deque model.
// Depends on cdeq_pkg and the core RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cdeq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int RANDOM_COMMANDS = 300;
  localparam int HOLD_CYCLES     = 300;

  typedef struct {
    req_t cmd_beat;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  elem_t     model_store [DEPTH];
  idx_t      model_head;
  idx_t      model_tail;
  bit        model_empty;
  rsp_t      model_beats [$];
  rsp_t      expected_beats [$];
  plan_row_t plan [$];
  int        mismatches;
  int        burst_left;
  bit        hold_request;

  circular_double_ended_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  function automatic idx_t wrap_inc(idx_t i);
    return idx_t'((int'(i) + 1) % DEPTH);
  endfunction

  function automatic idx_t wrap_dec(idx_t i);
    return idx_t'((int'(i) + DEPTH - 1) % DEPTH);
  endfunction

  function automatic bit model_full();
    return !model_empty && model_head == wrap_inc(model_tail);
  endfunction

  function automatic void model_beat(logic [STATUS_W-1:0] st, elem_t d, bit fin);
    rsp_t b;
    b.status   = st;
    b.data_out = PORT_W'(d);
    b.last     = fin;
    b.is_full  = model_full();
    b.is_empty = model_empty;
    model_beats.push_back(b);
  endfunction

  function automatic void deque_model_step(req_t r);
    elem_t popped;
    idx_t  i;
    int    n;
    bit    fin;
    case (r.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (model_full()) begin
          model_beat(STATUS_OVERFLOW, '0, 1'b1);
        end else begin
          if (model_empty) begin
            model_head     = '0;
            model_tail     = '0;
            model_empty    = 1'b0;
            model_store[0] = elem_t'(r.data_in);
          end else if (r.cmd == CMD_PUSH_FRONT) begin
            model_head              = wrap_dec(model_head);
            model_store[model_head] = elem_t'(r.data_in);
          end else begin
            model_tail              = wrap_inc(model_tail);
            model_store[model_tail] = elem_t'(r.data_in);
          end
          model_beat(STATUS_OK, '0, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (model_empty) begin
          model_beat(STATUS_UNDERFLOW, '0, 1'b1);
        end else begin
          popped = (r.cmd == CMD_POP_FRONT) ? model_store[model_head] : model_store[model_tail];
          if (model_head == model_tail) begin
            model_empty = 1'b1;
            model_head  = '0;
            model_tail  = '0;
          end else if (r.cmd == CMD_POP_FRONT) begin
            model_head = wrap_inc(model_head);
          end else begin
            model_tail = wrap_dec(model_tail);
          end
          model_beat(STATUS_OK, popped, 1'b1);
        end
      end
      CMD_DISPLAY: begin
        if (model_empty) begin
          model_beat(STATUS_EMPTY, '0, 1'b1);
        end else begin
          i = model_head;
          for (n = 0; n < DEPTH; n++) begin
            fin = (i == model_tail) || (n == DEPTH - 1);
            model_beat(STATUS_OK, model_store[i], fin);
            if (fin) begin
              break;
            end
            i = wrap_inc(i);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic plan_row_t row(logic [CMD_W-1:0] c, logic [PORT_W-1:0] d,
                                    bit typed = 1'b0, logic [STATUS_W-1:0] st = STATUS_OK,
                                    logic [PORT_W-1:0] dout = '0, bit full = 1'b0,
                                    bit empty = 1'b0);
    plan_row_t p;
    p.cmd_beat.cmd     = c;
    p.cmd_beat.data_in = d;
    p.typed            = typed;
    p.want.status      = st;
    p.want.data_out    = dout;
    p.want.last        = 1'b1;
    p.want.is_full     = full;
    p.want.is_empty    = empty;
    return p;
  endfunction

  function automatic logic [PORT_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_command(int push_share);
    req_t r;
    int   roll;
    roll      = $urandom_range(0, 99);
    r.data_in = pick_word();
    if (roll < 3) begin
      r.cmd = CMD_W'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
    end else if (roll < 12) begin
      r.cmd = CMD_DISPLAY;
    end else if ($urandom_range(0, 99) < push_share) begin
      r.cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
    end else begin
      r.cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [PORT_W-1:0] got, logic [PORT_W-1:0] want);
    $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Hands one command to the block and, once it is taken, queues the beats it should cause.
  task automatic offer(req_t r, bit typed = 1'b0, rsp_t want = '0);
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) begin
      @(posedge clk);
    end
    model_beats.delete();
    deque_model_step(r);
    if (typed) begin
      expected_beats.push_back(want);
    end else begin
      foreach (model_beats[k]) begin
        expected_beats.push_back(model_beats[k]);
      end
    end
  endtask

  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    while (expected_beats.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int    taken;
    int    push_share;
    int    phase_left;
    req_t  r;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    mismatches   = 0;
    burst_left   = 1;
    hold_request = 1'b0;
    model_empty  = 1'b1;
    model_head   = '0;
    model_tail   = '0;
    foreach (model_store[k]) begin
      model_store[k] = '0;
    end

    plan.push_back(row(CMD_POP_FRONT,  '0, 1'b1, STATUS_UNDERFLOW, '0, 1'b0, 1'b1));
    plan.push_back(row(CMD_POP_REAR,   '0, 1'b1, STATUS_UNDERFLOW, '0, 1'b0, 1'b1));
    plan.push_back(row(CMD_DISPLAY,    '0, 1'b1, STATUS_EMPTY,     '0, 1'b0, 1'b1));
    plan.push_back(row(CMD_SPARE_5,    32'h1234_5678));
    plan.push_back(row(CMD_PUSH_REAR,  32'h7fff_ffff, 1'b1, STATUS_OK, '0, 1'b0, 1'b0));
    plan.push_back(row(CMD_POP_REAR,   '0, 1'b1, STATUS_OK, 32'h7fff_ffff, 1'b0, 1'b1));
    plan.push_back(row(CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, STATUS_OK, '0, 1'b0, 1'b0));
    plan.push_back(row(CMD_POP_FRONT,  '1, 1'b1, STATUS_OK, 32'h8000_0000, 1'b0, 1'b1));
    plan.push_back(row(CMD_PUSH_FRONT, 32'hffff_ffff));
    plan.push_back(row(CMD_PUSH_REAR,  32'h0000_0000));
    plan.push_back(row(CMD_PUSH_FRONT, 32'h5555_5555));
    plan.push_back(row(CMD_PUSH_REAR,  32'haaaa_aaaa));
    plan.push_back(row(CMD_PUSH_FRONT, 32'h0000_0001));
    plan.push_back(row(CMD_PUSH_REAR,  32'h8000_0000));
    plan.push_back(row(CMD_PUSH_FRONT, 32'h7fff_ffff));
    plan.push_back(row(CMD_PUSH_REAR,  32'h1234_5678));
    plan.push_back(row(CMD_PUSH_FRONT, 32'hdead_beef, 1'b1, STATUS_OVERFLOW, '0, 1'b1, 1'b0));
    plan.push_back(row(CMD_PUSH_REAR,  32'hcafe_f00d, 1'b1, STATUS_OVERFLOW, '0, 1'b1, 1'b0));
    plan.push_back(row(CMD_DISPLAY,    '0));
    plan.push_back(row(CMD_SPARE_6,    '0));
    plan.push_back(row(CMD_SPARE_7,    32'hffff_ffff));
    plan.push_back(row(CMD_POP_FRONT,  '0));
    plan.push_back(row(CMD_POP_REAR,   '0));
    plan.push_back(row(CMD_DISPLAY,    '0));
    plan.push_back(row(CMD_PUSH_REAR,  32'h0f0f_0f0f));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      offer(plan[k].cmd_beat, plan[k].typed, plan[k].want);
      pace_sender();
    end

    // Random part: the push share swings between phases so the queue runs between empty
    // and full and wraps its indices many times.
    taken      = 0;
    phase_left = 0;
    push_share = 50;
    while (taken < RANDOM_COMMANDS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0: push_share = 20;
          1: push_share = 50;
          default: push_share = 80;
        endcase
      end
      phase_left--;
      if (taken == 40) begin
        hold_request = 1'b1;
      end
      r = random_command(push_share);
      offer(r);
      if (r.cmd <= CMD_DISPLAY) begin
        taken++;
      end
      if (taken == RANDOM_COMMANDS / 2 && r.cmd <= CMD_DISPLAY) begin
        req_valid <= 1'b0;
        drain_results();
      end
      pace_sender();
    end

    req_valid <= 1'b0;
    drain_results();
    repeat (12) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int mode;
    int span;
    rsp_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 60);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_request) begin
          rsp_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_request = 1'b0;
        end else begin
          case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 2) != 0);
            default: rsp_ready <= (k % 4 == 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_beats.size() == 0) begin
        note_mismatch("beat with nothing outstanding", rsp.data_out, '0);
      end else begin
        want = expected_beats.pop_front();
        if (rsp.status !== want.status) begin
          note_mismatch("status", rsp.status, want.status);
        end
        if (rsp.data_out !== want.data_out) begin
          note_mismatch("data_out", rsp.data_out, want.data_out);
        end
        if (rsp.last !== want.last) begin
          note_mismatch("last", rsp.last, want.last);
        end
        if (rsp.is_full !== want.is_full) begin
          note_mismatch("is_full", rsp.is_full, want.is_full);
        end
        if (rsp.is_empty !== want.is_empty) begin
          note_mismatch("is_empty", rsp.is_empty, want.is_empty);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ files.f @@
src/cdeq_pkg.sv
src/circular_double_ended_queue_core.sv
sim/tb_top.sv
